// ----- rtl/lmrq_pkg.sv -----
package lmrq_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int SLOT_BYTES_DEF = 192;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_LOG_EN = 1'b0;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_DISCARDED = 3'd3,
        ST_FULL      = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;      // push item accepted this cycle
        logic pop;       // pop item accepted this cycle, memory read issued
        logic pop_done;  // read data is back, finish the pop
    } t_cmd;

    // Configuration write handed to the datapath.
    typedef struct packed {
        logic we;
        logic log_en;
    } t_cfg;

endpackage

// ----- rtl/lmrq_if.sv -----
interface lmrq_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output mode, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input mode, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface lmrq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] push_status;
    logic       push_ok;
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       pop_last;

    modport source (output valid, output push_status, output push_ok, output pop_valid,
                    output pop_byte, output pop_last, input ready);
    modport sink   (input valid, input push_status, input push_ok, input pop_valid,
                    input pop_byte, input pop_last, output ready);
endinterface

// ----- rtl/lmrq_ctrl.sv -----
module lmrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output lmrq_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    // A new item may enter only when the result register is free or being drained.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.push     = accept && (i_in_mode == lmrq_pkg::MODE_PUSH);
    assign o_cmd.pop      = accept && (i_in_mode == lmrq_pkg::MODE_POP);
    assign o_cmd.pop_done = (r_state == S_READ);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.push || o_cmd.pop_done) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/lmrq_dp.sv -----
module lmrq_dp #(
    parameter int SLOT_COUNT = lmrq_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = lmrq_pkg::SLOT_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmrq_pkg::t_cmd  i_cmd,
    input  lmrq_pkg::t_cfg  i_cfg,
    input  logic [7:0]      i_data_byte,
    input  logic            i_has_byte,
    input  logic            i_end_of_message,
    output logic            o_log_en,
    output logic [2:0]      o_push_status,
    output logic            o_push_ok,
    output logic            o_pop_valid,
    output logic [7:0]      o_pop_byte,
    output logic            o_pop_last
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_BYTES + 2);
    localparam int LW    = $clog2(SLOT_BYTES + 1);
    localparam int OW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] SB_C      = CW'(SLOT_BYTES);
    localparam logic [AW-1:0] SB_A      = AW'(SLOT_BYTES);

    logic [7:0]    r_store [DEPTH];
    logic [LW-1:0] r_len   [SLOT_COUNT];

    logic [SW-1:0] r_write_slot;
    logic [SW-1:0] r_read_slot;
    logic [CW-1:0] r_push_count;
    logic [OW-1:0] r_pop_offset;
    logic          r_log_en;
    logic          r_pop_empty;
    logic [7:0]    r_rd_byte;
    logic [LW-1:0] r_rd_len;

    logic [2:0]    r_push_status;
    logic          r_push_ok;
    logic          r_pop_valid;
    logic [7:0]    r_pop_byte;
    logic          r_pop_last;

    logic [SW-1:0] n_write_slot;
    logic [SW-1:0] n_read_slot;
    logic [CW-1:0] n_push_count;
    logic [OW-1:0] n_pop_offset;

    logic [CW-1:0]       count_inc;
    logic                store_we;
    logic                len_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [SW-1:0]       write_next;
    logic [SW-1:0]       read_next;
    logic                pop_is_last;
    lmrq_pkg::t_status   push_st;

    assign write_next = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + SW'(1);
    assign read_next  = (r_read_slot == LAST_SLOT) ? '0 : r_read_slot + SW'(1);

    assign count_inc = (i_has_byte && (r_push_count <= SB_C)) ? r_push_count + CW'(1)
                                                               : r_push_count;
    assign store_we  = i_cmd.push && i_has_byte && (r_push_count < SB_C);

    assign wr_addr = AW'(r_write_slot) * SB_A + AW'(r_push_count);
    assign rd_addr = AW'(r_read_slot) * SB_A + AW'(r_pop_offset);

    // Offset is below the slot size, so offset + 1 always fits the length width.
    assign pop_is_last = ((LW'(r_pop_offset) + LW'(1)) >= r_rd_len);

    // Judgment of a message end, in priority order.
    always_comb begin
        push_st = lmrq_pkg::ST_PENDING;
        if (i_end_of_message) begin
            if (count_inc == '0) begin
                push_st = lmrq_pkg::ST_EMPTY;
            end else if (count_inc > SB_C) begin
                push_st = lmrq_pkg::ST_TOO_LONG;
            end else if (!r_log_en) begin
                push_st = lmrq_pkg::ST_DISCARDED;
            end else if (write_next == r_read_slot) begin
                push_st = lmrq_pkg::ST_FULL;
            end else begin
                push_st = lmrq_pkg::ST_QUEUED;
            end
        end
    end

    assign len_we = i_cmd.push && (push_st == lmrq_pkg::ST_QUEUED);

    always_comb begin
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_push_count = r_push_count;
        n_pop_offset = r_pop_offset;

        if (i_cmd.push) begin
            n_push_count = i_end_of_message ? '0 : count_inc;
            if (len_we) begin
                n_write_slot = write_next;
            end
        end

        if (i_cmd.pop_done && !r_pop_empty) begin
            if (pop_is_last) begin
                n_pop_offset = '0;
                n_read_slot  = read_next;
            end else begin
                n_pop_offset = r_pop_offset + OW'(1);
            end
        end

        // Writing logging off drops everything queued, a partly read head too.
        if (i_cfg.we && !i_cfg.log_en) begin
            n_read_slot  = r_write_slot;
            n_pop_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_push_count <= '0;
            r_pop_offset <= '0;
            r_log_en     <= 1'b0;
        end else begin
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_push_count <= n_push_count;
            r_pop_offset <= n_pop_offset;
            if (i_cfg.we) begin
                r_log_en <= i_cfg.log_en;
            end
        end
    end

    // Message bytes and slot lengths.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[wr_addr] <= i_data_byte;
        end
        if (len_we) begin
            r_len[r_write_slot] <= LW'(count_inc);
        end
        if (i_cmd.pop) begin
            r_rd_byte   <= r_store[rd_addr];
            r_rd_len    <= r_len[r_read_slot];
            r_pop_empty <= (r_read_slot == r_write_slot);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_push_status <= push_st;
            r_push_ok     <= (push_st == lmrq_pkg::ST_QUEUED) ||
                             (push_st == lmrq_pkg::ST_EMPTY) ||
                             (push_st == lmrq_pkg::ST_DISCARDED);
            r_pop_valid   <= 1'b0;
            r_pop_byte    <= '0;
            r_pop_last    <= 1'b0;
        end else if (i_cmd.pop_done) begin
            r_push_status <= lmrq_pkg::ST_PENDING;
            r_push_ok     <= 1'b0;
            r_pop_valid   <= !r_pop_empty;
            r_pop_byte    <= r_pop_empty ? 8'd0 : r_rd_byte;
            r_pop_last    <= !r_pop_empty && pop_is_last;
        end
    end

    assign o_log_en      = r_log_en;
    assign o_push_status = r_push_status;
    assign o_push_ok     = r_push_ok;
    assign o_pop_valid   = r_pop_valid;
    assign o_pop_byte    = r_pop_byte;
    assign o_pop_last    = r_pop_last;

endmodule

// ----- rtl/log_message_ring_queue_top.sv -----
// Ring queue of debug text messages.
// Input channel i_in carries one item per transfer: a push (an optional message
// byte, an optional end mark) or a pop (next byte of the head message). Output
// channel o_out returns exactly one result per input item, in order.
// A push result is ready in the cycle after its transfer. A pop result passes
// the memory read register and then the output register, since the message
// bytes sit in a memory with a registered read port; the block holds one item
// at a time.
// The result sits in an output register; while the receiver stalls it is
// held and no new item is taken, nothing is lost.
// The APB port holds the log enable bit at address 0; writing 0 empties the ring.
// Reset clears the slot pointers, the byte count, the read offset and
// the log enable bit; the message memory needs no clearing pass, since only
// queued slots ever reach the output. The ring holds SLOT_COUNT - 1 messages.
module log_message_ring_queue_top #(
    parameter int SLOT_COUNT = lmrq_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = lmrq_pkg::SLOT_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lmrq_in_if.sink                         i_in,
    lmrq_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lmrq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lmrq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lmrq_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    lmrq_pkg::t_cmd cmd;
    lmrq_pkg::t_cfg cfg;
    logic           log_en;
    logic           reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == lmrq_pkg::REG_IDX_LOG_EN);

    assign cfg.we     = psel && penable && pwrite && pready && reg_hit;
    assign cfg.log_en = pwdata[0];

    assign prdata = reg_hit ? {{(lmrq_pkg::APB_DATA_W-1){1'b0}}, log_en} : '0;

    lmrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    lmrq_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_data_byte      (i_in.data_byte),
        .i_has_byte       (i_in.has_byte),
        .i_end_of_message (i_in.end_of_message),
        .o_log_en         (log_en),
        .o_push_status    (o_out.push_status),
        .o_push_ok        (o_out.push_ok),
        .o_pop_valid      (o_out.pop_valid),
        .o_pop_byte       (o_out.pop_byte),
        .o_pop_last       (o_out.pop_last)
    );

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.mode == lmrq_pkg::MODE_PUSH)) |=> o_out.valid)
        else $error("push transfer did not produce a result");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.mode == lmrq_pkg::MODE_POP)) |=> !i_in.ready)
        else $error("input taken while a pop read is in flight");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.mode == lmrq_pkg::MODE_POP)) |-> ##2 o_out.valid)
        else $error("pop transfer did not produce a result");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while the result register is stalled");

endmodule

// ----- tb/log_message_ring_queue_top_test.sv -----
`timescale 1ns / 1ps

module log_message_ring_queue_top_test;

    localparam int CLK_PERIOD     = 10;
    localparam int SLOT_COUNT     = lmrq_pkg::SLOT_COUNT_DEF;
    localparam int SLOT_BYTES     = lmrq_pkg::SLOT_BYTES_DEF;
    localparam int LOGS_REG       = int'(lmrq_pkg::REG_IDX_LOG_EN);
    localparam int SPARE_REG      = 1;
    localparam int DRAIN_TAIL     = 4;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int TRAFFIC_ITEMS  = 120;

    typedef struct {
        lmrq_pkg::t_status status;
        logic              ok;
        logic              pvalid;
        logic [7:0]        pbyte;
        logic              plast;
    } t_ring_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lmrq_pkg::APB_ADDR_W-1:0] paddr;
    logic [lmrq_pkg::APB_DATA_W-1:0] pwdata;
    logic [lmrq_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    lmrq_in_if  in_if();
    lmrq_out_if out_if();

    log_message_ring_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the ring.
    logic [7:0] msg_mem [SLOT_COUNT][SLOT_BYTES];
    int         msg_len [SLOT_COUNT];
    int         wr_slot;
    int         rd_slot;
    int         fill_count;
    int         rd_offset;
    logic       logs_on;

    t_ring_result awaited_results[$];
    int           mismatch_count = 0;
    int           useful_items = 0;
    int           stalled_cycles = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_wait = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;

    function automatic t_ring_result advance_ring(logic mode, logic [7:0] data,
                                                  logic has_byte, logic eom);
        t_ring_result r;
        int nxt;
        r.status = lmrq_pkg::ST_PENDING;
        r.ok     = 1'b0;
        r.pvalid = 1'b0;
        r.pbyte  = 8'h00;
        r.plast  = 1'b0;
        if (mode == lmrq_pkg::MODE_PUSH) begin
            if (has_byte) begin
                if (fill_count < SLOT_BYTES) msg_mem[wr_slot][fill_count] = data;
                // The count stops one past the slot size, which flags the message too long.
                if (fill_count <= SLOT_BYTES) fill_count++;
            end
            if (eom) begin
                nxt = (wr_slot + 1) % SLOT_COUNT;
                if (fill_count == 0) begin
                    r.status = lmrq_pkg::ST_EMPTY;
                    r.ok     = 1'b1;
                end else if (fill_count > SLOT_BYTES) begin
                    r.status = lmrq_pkg::ST_TOO_LONG;
                end else if (!logs_on) begin
                    r.status = lmrq_pkg::ST_DISCARDED;
                    r.ok     = 1'b1;
                end else if (nxt == rd_slot) begin
                    r.status = lmrq_pkg::ST_FULL;
                end else begin
                    msg_len[wr_slot] = fill_count;
                    wr_slot  = nxt;
                    r.status = lmrq_pkg::ST_QUEUED;
                    r.ok     = 1'b1;
                end
                fill_count = 0;
            end
        end else if (rd_slot != wr_slot) begin
            r.pvalid = 1'b1;
            r.pbyte  = msg_mem[rd_slot][rd_offset];
            if (rd_offset + 1 >= msg_len[rd_slot]) begin
                r.plast   = 1'b1;
                rd_offset = 0;
                rd_slot   = (rd_slot + 1) % SLOT_COUNT;
            end else begin
                rd_offset++;
            end
        end
        return r;
    endfunction

    function automatic void apply_register_write(int idx, logic [31:0] value);
        if (idx == LOGS_REG) begin
            logs_on = value[0];
            if (!logs_on) begin
                rd_slot   = wr_slot;
                rd_offset = 0;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(logic mode, logic [7:0] data, logic has_byte, logic eom);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid          <= 1'b1;
        in_if.mode           <= mode;
        in_if.data_byte      <= data;
        in_if.has_byte       <= has_byte;
        in_if.end_of_message <= eom;
        do @(posedge i_clk); while (!in_if.ready);
        awaited_results.push_back(advance_ring(mode, data, has_byte, eom));
        if (!(mode == lmrq_pkg::MODE_PUSH && !has_byte && !eom)) useful_items++;
    endtask

    task automatic push_byte(logic [7:0] data, logic eom);
        send_item(lmrq_pkg::MODE_PUSH, data, 1'b1, eom);
    endtask

    task automatic pop_one();
        send_item(lmrq_pkg::MODE_POP, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Random bytes; the end mark rides on the last byte or on a byte-less item after it.
    task automatic send_message(int len, bit end_alone, bit noisy);
        bit last;
        if (len == 0) begin
            send_item(lmrq_pkg::MODE_PUSH, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1) && !end_alone;
            push_byte(8'($urandom), last);
            if (noisy && i != len - 1 && $urandom_range(0, 99) < 6) begin
                if ($urandom_range(0, 1) == 1) pop_one();
                else send_item(lmrq_pkg::MODE_PUSH, 8'($urandom), 1'b0, 1'b0);
            end
        end
        if (end_alone) send_item(lmrq_pkg::MODE_PUSH, 8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic cfg_write(int idx, logic [31:0] value);
        wait_drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lmrq_pkg::APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register_write(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read_check();
        wait_drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= lmrq_pkg::APB_ADDR_W'(LOGS_REG * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'b0, logs_on})
            report_mismatch("log enable readback", prdata, logs_on);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: a stall drawn per transfer, plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_if.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_ring_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rx_wait = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing outstanding, push_status",
                                out_if.push_status, 0);
            end else begin
                want = awaited_results.pop_front();
                if (out_if.push_status !== want.status)
                    report_mismatch("push_status", out_if.push_status, want.status);
                if (out_if.push_ok !== want.ok)
                    report_mismatch("push_ok", out_if.push_ok, want.ok);
                if (out_if.pop_valid !== want.pvalid)
                    report_mismatch("pop_valid", out_if.pop_valid, want.pvalid);
                if (out_if.pop_byte !== want.pbyte)
                    report_mismatch("pop_byte", out_if.pop_byte, want.pbyte);
                if (out_if.pop_last !== want.plast)
                    report_mismatch("pop_last", out_if.pop_last, want.plast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_disabled_after_reset();
        cfg_read_check();
        pop_one();
        send_item(lmrq_pkg::MODE_PUSH, 8'hA5, 1'b0, 1'b1);
        send_item(lmrq_pkg::MODE_PUSH, 8'h5A, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        pop_one();
    endtask

    task automatic test_basic_queue();
        cfg_write(LOGS_REG, 32'd1);
        cfg_read_check();
        push_byte(8'h41, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b1);
        push_byte(8'hAA, 1'b0);
        // A pop in the middle of a push reads the head, not the open message.
        pop_one();
        push_byte(8'h7E, 1'b0);
        send_item(lmrq_pkg::MODE_PUSH, 8'h00, 1'b0, 1'b1);
        send_item(lmrq_pkg::MODE_PUSH, 8'hFF, 1'b0, 1'b1);
        repeat (7) pop_one();
    endtask

    task automatic test_flush_cases();
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b1);
        push_byte(8'h44, 1'b1);
        pop_one();
        cfg_write(LOGS_REG, 32'd0);
        pop_one();
        cfg_write(LOGS_REG, 32'd1);
        pop_one();
        // A message in progress is judged by the register value at its end.
        push_byte(8'h81, 1'b0);
        push_byte(8'h82, 1'b0);
        cfg_write(LOGS_REG, 32'd0);
        push_byte(8'h83, 1'b1);
        push_byte(8'h91, 1'b0);
        push_byte(8'h92, 1'b0);
        cfg_write(LOGS_REG, 32'd1);
        send_item(lmrq_pkg::MODE_PUSH, 8'h00, 1'b0, 1'b1);
        // A write to an unmapped register must not flush.
        cfg_write(SPARE_REG, 32'd0);
        cfg_read_check();
        repeat (3) pop_one();
    endtask

    task automatic test_slot_limits();
        cfg_write(LOGS_REG, 32'd0);
        cfg_write(LOGS_REG, 32'd1);
        send_message(SLOT_BYTES, 1'b0, 1'b0);
        // Two bytes past the slot size, with the end mark on an item of its own.
        send_message(SLOT_BYTES + 2, 1'b1, 1'b0);
        repeat (4) pop_one();
        // The partly read full-size message is dropped by the flush.
        cfg_write(LOGS_REG, 32'd0);
        pop_one();
    endtask

    task automatic test_ring_full_with_backpressure();
        int first_len;
        cfg_write(LOGS_REG, 32'd0);
        cfg_write(LOGS_REG, 32'd1);
        // The receiver holds off while the sender keeps offering transfers.
        rx_hold_req = LONG_HOLD;
        first_len = $urandom_range(1, 3);
        send_message(first_len, 1'b0, 1'b0);
        for (int i = 1; i < SLOT_COUNT + 1; i++) send_message($urandom_range(1, 3), 1'b0, 1'b0);
        wait_drain();
        repeat (first_len) pop_one();
        send_message(2, 1'b0, 1'b0);
        send_message(1, 1'b1, 1'b0);
        cfg_write(LOGS_REG, 32'd0);
        pop_one();
        cfg_write(LOGS_REG, 32'd1);
    endtask

    task automatic run_traffic(int n_items, int push_pct);
        int stop_at;
        int pick;
        int len;
        stop_at = useful_items + n_items;
        while (useful_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) len = 0;
                else if (pick < 90) len = $urandom_range(1, 8);
                else len = $urandom_range(9, 40);
                send_message(len, 1'($urandom), 1'b1);
            end else if (pick < 97) begin
                repeat ($urandom_range(1, 10)) pop_one();
            end else begin
                send_item(lmrq_pkg::MODE_PUSH, 8'($urandom), 1'b0, 1'b0);
            end
        end
    endtask

    task automatic test_random_traffic();
        cfg_write(LOGS_REG, 32'd1);
        run_traffic(TRAFFIC_ITEMS / 4, 55);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        cfg_write(LOGS_REG, 32'd1);
        run_traffic(TRAFFIC_ITEMS / 4, 75);
        rx_idle_on = 1'b1;
        cfg_write(LOGS_REG, 32'd0);
        run_traffic(TRAFFIC_ITEMS / 4, 60);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        cfg_write(LOGS_REG, 32'd1);
        run_traffic(TRAFFIC_ITEMS / 4, 40);
        rx_idle_on = 1'b1;
        cfg_read_check();
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_if.valid           = 1'b0;
        in_if.mode            = lmrq_pkg::MODE_PUSH;
        in_if.data_byte       = 8'h00;
        in_if.has_byte        = 1'b0;
        in_if.end_of_message  = 1'b0;
        out_if.ready          = 1'b0;
        wr_slot    = 0;
        rd_slot    = 0;
        fill_count = 0;
        rd_offset  = 0;
        logs_on    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_after_reset();
        test_basic_queue();
        test_flush_cases();
        test_slot_limits();
        test_ring_full_with_backpressure();
        test_random_traffic();

        wait_drain();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
